[hw/rtl/xed_pkg.sv]
package xed_pkg;

    localparam int unsigned NAME_COUNT = 5;
    localparam int unsigned NAME_MAX   = 5;
    localparam int unsigned HOLD_DEPTH = 4;
    localparam int unsigned JOB_BYTES  = 5;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    // reference names, index 0 in the lowest byte: lt; gt; amp; apos; quot;
    localparam logic [NAME_COUNT-1:0][NAME_MAX-1:0][7:0] NAME_TEXT = {
        {8'h3b, 8'h74, 8'h6f, 8'h75, 8'h71},
        {8'h3b, 8'h73, 8'h6f, 8'h70, 8'h61},
        {8'h00, 8'h3b, 8'h70, 8'h6d, 8'h61},
        {8'h00, 8'h00, 8'h3b, 8'h74, 8'h67},
        {8'h00, 8'h00, 8'h3b, 8'h74, 8'h6c}
    };

    localparam logic [NAME_COUNT-1:0][2:0] NAME_LEN = {3'd5, 3'd5, 3'd4, 3'd3, 3'd3};

    localparam logic [NAME_COUNT-1:0][7:0] NAME_CHAR = {8'h22, 8'h27, 8'h26, 8'h3e, 8'h3c};

    // one input transaction worth of output bytes; zero bytes means end marker
    typedef struct packed {
        logic                      last;
        logic [2:0]                n;
        logic [JOB_BYTES-1:0][7:0] bytes;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[hw/rtl/xed_front.sv]
module xed_front import xed_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  q_stat_t     q_stat,
    output logic        push,
    output job_t        push_job
);

    logic                       in_ref_reg, in_ref_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic [HOLD_DEPTH-1:0][7:0] held_reg;
    logic                       accept;
    logic                       hold;
    logic [7:0]                 b;
    logic [JOB_BYTES-1:0][7:0]  cand;
    logic [JOB_BYTES-1:0][7:0]  held_ext;
    logic [2:0]                 len_c;
    logic [NAME_COUNT-1:0]      full_m, pre_m;
    logic                       ok;
    logic [7:0]                 ch;
    logic [7:0]                 x;
    logic [2:0]                 cnt_eff;
    logic [2:0]                 n;

    assign b        = s_tdata;
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign len_c    = cnt_reg + 3'd1;
    assign held_ext = {8'h00, held_reg};

    // candidate name so far: held bytes then the current byte
    always_comb begin
        for (int i = 0; i < JOB_BYTES; i++) begin
            cand[i] = (3'(i) < cnt_reg) ? held_ext[i] : b;
        end
    end

    always_comb begin
        ch = 8'h00;
        for (int k = 0; k < NAME_COUNT; k++) begin
            ok = (len_c <= NAME_LEN[k]);
            for (int i = 0; i < NAME_MAX; i++) begin
                if (3'(i) < len_c && cand[i] != NAME_TEXT[k][i]) begin
                    ok = 1'b0;
                end
            end
            full_m[k] = ok && (len_c == NAME_LEN[k]);
            pre_m[k]  = ok && (len_c < NAME_LEN[k]);
            if (full_m[k]) begin
                ch = NAME_CHAR[k];
            end
        end
    end

    always_comb begin
        hold        = 1'b0;
        x           = b;
        cnt_eff     = 3'd0;
        n           = 3'd0;
        in_ref_next = in_ref_reg;
        cnt_next    = cnt_reg;
        if (!in_ref_reg) begin
            if (b == AMP_CHAR) begin
                in_ref_next = 1'b1;
                cnt_next    = 3'd0;
            end else begin
                n = 3'd1;
            end
        end else if (|full_m) begin
            x           = ch;
            n           = 3'd1;
            in_ref_next = 1'b0;
            cnt_next    = 3'd0;
        end else if ((|pre_m) && cnt_reg < 3'(HOLD_DEPTH)) begin
            hold     = 1'b1;
            cnt_eff  = cnt_reg;
            cnt_next = cnt_reg + 3'd1;
            n        = s_tlast ? cnt_reg + 3'd1 : 3'd0;
        end else begin
            cnt_eff     = cnt_reg;
            n           = cnt_reg + ((b != AMP_CHAR) ? 3'd1 : 3'd0);
            in_ref_next = (b == AMP_CHAR);
            cnt_next    = 3'd0;
        end
        if (s_tlast) begin
            in_ref_next = 1'b0;
            cnt_next    = 3'd0;
        end
    end

    always_comb begin
        for (int i = 0; i < JOB_BYTES; i++) begin
            push_job.bytes[i] = (3'(i) < cnt_eff) ? held_ext[i] : x;
        end
        push_job.n    = n;
        push_job.last = s_tlast;
    end

    assign push = accept && (n != 3'd0 || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ref_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end else if (accept) begin
            in_ref_reg <= in_ref_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hold) begin
            held_reg[cnt_reg[1:0]] <= b;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(HOLD_DEPTH))
        else $error("held count beyond hold depth");
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ref_reg |-> cnt_reg == 3'd0)
        else $error("bytes held outside a reference");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> !in_ref_reg && cnt_reg == 3'd0)
        else $error("match state survived the final byte");
`endif

endmodule

[hw/rtl/xed_queue.sv]
module xed_queue import xed_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head,
    output q_stat_t q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/xed_back.sv]
module xed_back import xed_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        head,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [1:0]  m_tuser
);

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;
    logic [1:0] m_user_reg;
    logic       load;
    logic       marker;
    logic       final_rec;

    assign marker    = (head.n == 3'd0);
    assign final_rec = marker || (idx_reg == head.n - 3'd1);
    assign load      = !q_stat.empty && (!m_valid_reg || m_tready);
    assign pop       = load && final_rec;

    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 3'd0;
        end else if (load) begin
            idx_next = idx_reg + 3'd1;
        end
        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= marker ? 8'h00 : head.bytes[idx_reg];
            m_last_reg <= final_rec;
            m_user_reg <= {final_rec && head.last, !marker};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_stat.empty && !marker |-> idx_reg < head.n)
        else $error("byte index past the end of the job");
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("stream end without run end");
    a_marker_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && m_tuser[1] && m_tlast)
        else $error("malformed end marker");
`endif

endmodule

[hw/rtl/xml_entity_decoder_top.sv]
// channel   dir  tdata            tlast       tuser
// s_        in   [7:0] byte_in    last_in     -
// m_        out  [7:0] byte_out   run_last    [0] byte_valid, [1] stream_end
//
// one input transaction per cycle while the job queue has room
// an input causing k results gives k output transfers, one byte each (k up to 5)
// a bare end marker or a single byte takes one output transfer
// input stalls only when the QUEUE_DEPTH job queue is full
// aresetn is synchronous and active low; held match bytes need no reset
module xml_entity_decoder_top import xed_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] byte_out
    output logic        m_tlast,
    output logic [1:0]  m_tuser     // [0] byte_valid, [1] stream_end
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head;

    xed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    xed_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
